[hdl/cbrs_pkg.sv]
// constants and field widths shared by the busy ratio sampler
// no dependencies; used by core_busy_ratio_sampler_top
package cbrs_pkg;

	// field widths
	localparam int unsigned REQ_BITS      = 1;
	localparam int unsigned CORE_BITS     = 1;
	localparam int unsigned IN_CNT_BITS   = 32;
	localparam int unsigned USAGE_BITS    = 10;
	localparam int unsigned PERIOD_BITS   = 10;

	// counter width default
	localparam int unsigned COUNTER_BITS_DEF = 32;

	// tick period register reset value, milliseconds
	localparam logic [PERIOD_BITS-1:0] TICK_PERIOD_RESET = 10'd10;

	// ms to us and per mille scale, both 1000
	localparam int unsigned SCALE       = 1000;
	// width of tick_period_ms * 1000 (at most 1023000)
	localparam int unsigned KBITS       = 20;
	// width of the scale multiplier
	localparam int unsigned SCALE_BITS  = 10;
	// quotient bits: the result never exceeds 1000
	localparam int unsigned QBITS       = 11;

	localparam logic [USAGE_BITS-1:0] USAGE_MAX = 10'd1000;

	// request codes
	localparam logic [REQ_BITS-1:0] REQ_SAMPLE  = 1'b0;
	localparam logic [REQ_BITS-1:0] REQ_RESTART = 1'b1;

endpackage

[hdl/core_busy_ratio_sampler_top.sv]
// busy ratio sampler for two cores, bit-serial shift-add and restoring divide
// depends on cbrs_pkg
//
// usage:
//  - input channel (in_valid/in_ready) carries one beat per request:
//    a restart of both cores, or a sample of one core's tick and idle counters
//  - output channel (out_valid/out_ready) returns one beat per request with
//    both cores' latest busy per mille and a joint valid flag
//  - user writes tick_period_ms with cfg_we when idle; block does not enforce
//  - one request is worked on at a time; in_ready is high only when idle
//  - a restart, a first sample after restart or a zero-elapsed sample goes
//    straight to the output step; a measured sample runs through
//    20 shift-add steps for ticks * period * 1000 (one per bit of the 20-bit
//    period factor), 10 steps for busy * 1000, 11 restoring divide steps
//    (one per quotient bit), plus setup, write-back and output steps
//  - the finished beat sits in an output register; while the receiver
//    stalls the block still takes and works on the next request and only
//    waits at its own output step until the register frees up
//  - reset (arst_n low) marks both cores restart pending, clears usage and
//    valid flags, zeroes the baselines and sets tick_period_ms to 10
//  - counters wrap at COUNTER_BITS bits
module core_busy_ratio_sampler_top #(
	parameter int unsigned COUNTER_BITS = cbrs_pkg::COUNTER_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_we,
	input  logic [cbrs_pkg::PERIOD_BITS-1:0]    tick_period_ms,
	// request channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [cbrs_pkg::REQ_BITS-1:0]       req_type,
	input  logic [cbrs_pkg::CORE_BITS-1:0]      core_index,
	input  logic [cbrs_pkg::IN_CNT_BITS-1:0]    tick_count,
	input  logic [cbrs_pkg::IN_CNT_BITS-1:0]    idle_time_us,
	// result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [cbrs_pkg::USAGE_BITS-1:0]     core0_usage_permille,
	output logic [cbrs_pkg::USAGE_BITS-1:0]     core1_usage_permille,
	output logic                                both_valid
);

	// elapsed time width and numerator width
	localparam int unsigned EW = COUNTER_BITS + cbrs_pkg::KBITS;
	localparam int unsigned NW = EW + cbrs_pkg::SCALE_BITS + 1;
	localparam int unsigned UW = cbrs_pkg::USAGE_BITS;
	localparam int unsigned QW = cbrs_pkg::QBITS;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_EL,
		ST_PREP,
		ST_MUL_NUM,
		ST_DIV,
		ST_WB,
		ST_OUT
	} state_t;

	state_t state_q;

	// per-core state
	logic [COUNTER_BITS-1:0] prev_tick_q [2];
	logic [COUNTER_BITS-1:0] prev_idle_q [2];
	logic [1:0]              pending_q;
	logic [1:0]              vvalid_q;
	logic [UW-1:0]           usage_q [2];
	logic [cbrs_pkg::PERIOD_BITS-1:0] period_q;

	// serial datapath
	logic [NW-1:0]             mcand_q;  // shifted multiplicand
	logic [cbrs_pkg::KBITS-1:0] mplier_q; // multiplier, consumed lsb first
	logic [EW-1:0]             el_acc_q; // elapsed us accumulator
	logic [NW-1:0]             num_q;    // numerator, then remainder
	logic [NW-1:0]             dv_q;     // shifted divisor
	logic [QW-1:0]             quo_q;
	logic [COUNTER_BITS-1:0]   di_q;
	logic [cbrs_pkg::CORE_BITS-1:0] core_q;
	logic [4:0]                cnt_q;

	logic                    in_fire;
	logic [COUNTER_BITS-1:0] tick_m;
	logic [COUNTER_BITS-1:0] idle_m;
	logic [COUNTER_BITS-1:0] dt;
	logic [COUNTER_BITS-1:0] di;
	logic [EW-1:0]           idle_clamp;
	logic [EW-1:0]           busy;
	logic                    div_ge;
	logic [UW-1:0]           usage_sat;
	logic                    out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;

	// counters masked or extended to the counter width
	assign tick_m = COUNTER_BITS'(tick_count);
	assign idle_m = COUNTER_BITS'(idle_time_us);
	assign dt     = tick_m - prev_tick_q[core_index];
	assign di     = idle_m - prev_idle_q[core_index];

	// idle time never exceeds elapsed time
	assign idle_clamp = (EW'(di_q) >= el_acc_q) ? el_acc_q : EW'(di_q);
	assign busy       = el_acc_q - idle_clamp;

	assign div_ge    = (num_q >= dv_q);
	assign usage_sat = (quo_q > QW'(cbrs_pkg::USAGE_MAX)) ? cbrs_pkg::USAGE_MAX
	                                                     : quo_q[UW-1:0];

	// control, per-core state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q              <= ST_IDLE;
			prev_tick_q[0]       <= '0;
			prev_tick_q[1]       <= '0;
			prev_idle_q[0]       <= '0;
			prev_idle_q[1]       <= '0;
			pending_q            <= 2'b11;
			vvalid_q             <= 2'b00;
			usage_q[0]           <= '0;
			usage_q[1]           <= '0;
			period_q             <= cbrs_pkg::TICK_PERIOD_RESET;
			cnt_q                <= '0;
			out_valid            <= 1'b0;
			core0_usage_permille <= '0;
			core1_usage_permille <= '0;
			both_valid           <= 1'b0;
		end else begin
			if (cfg_we) begin
				period_q <= tick_period_ms;
			end
			// the output step reloads the register itself
			if (out_valid && out_ready && state_q != ST_OUT) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_fire) begin
						if (req_type == cbrs_pkg::REQ_RESTART) begin
							// baselines kept until the next sample
							state_q    <= ST_OUT;
							pending_q  <= 2'b11;
							vvalid_q   <= 2'b00;
							usage_q[0] <= '0;
							usage_q[1] <= '0;
						end else begin
							prev_tick_q[core_index] <= tick_m;
							prev_idle_q[core_index] <= idle_m;
							if (pending_q[core_index]) begin
								state_q               <= ST_OUT;
								pending_q[core_index] <= 1'b0;
								vvalid_q[core_index]  <= 1'b0;
								usage_q[core_index]   <= '0;
							end else if (dt != '0 && period_q != '0) begin
								state_q <= ST_MUL_EL;
							end else begin
								state_q <= ST_OUT;
							end
						end
					end
				end
				ST_MUL_EL: begin
					if (cnt_q == 5'(cbrs_pkg::KBITS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_PREP;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_PREP: begin
					cnt_q   <= '0;
					state_q <= ST_MUL_NUM;
				end
				ST_MUL_NUM: begin
					if (cnt_q == 5'(cbrs_pkg::SCALE_BITS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_DIV: begin
					if (cnt_q == 5'(QW - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_WB;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_WB: begin
					usage_q[core_q]  <= usage_sat;
					vvalid_q[core_q] <= 1'b1;
					state_q          <= ST_OUT;
				end
				ST_OUT: begin
					// wait here while the previous beat is still unread
					if (out_free) begin
						out_valid            <= 1'b1;
						core0_usage_permille <= usage_q[0];
						core1_usage_permille <= usage_q[1];
						both_valid           <= vvalid_q[0] && vvalid_q[1];
						state_q              <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// serial datapath, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					mcand_q  <= NW'(dt);
					mplier_q <= cbrs_pkg::KBITS'(period_q) * cbrs_pkg::KBITS'(cbrs_pkg::SCALE);
					el_acc_q <= '0;
					di_q     <= di;
					core_q   <= core_index;
				end
			end
			ST_MUL_EL: begin
				// elapsed us = ticks * (period * 1000), one multiplier bit a step
				if (mplier_q[0]) begin
					el_acc_q <= el_acc_q + mcand_q[EW-1:0];
				end
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
			end
			ST_PREP: begin
				mcand_q  <= NW'(busy);
				mplier_q <= cbrs_pkg::KBITS'(cbrs_pkg::SCALE);
				// rounding half folded into the accumulator start
				num_q    <= NW'(el_acc_q >> 1);
				dv_q     <= NW'(el_acc_q) << (QW - 1);
				quo_q    <= '0;
			end
			ST_MUL_NUM: begin
				if (mplier_q[0]) begin
					num_q <= num_q + mcand_q;
				end
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
			end
			ST_DIV: begin
				// restoring divide, quotient msb first
				if (div_ge) begin
					num_q <= num_q - dv_q;
				end
				quo_q <= {quo_q[QW-2:0], div_ge};
				dv_q  <= dv_q >> 1;
			end
			ST_WB, ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

endmodule
